@@ design/sspc_pkg.sv @@
// Package for the servo status packet checker.
// Holds the verdict codes, the field widths and the packet view struct.
// No dependencies.
`default_nettype none

package sspc_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned RDCNT_W  = 6;
   localparam int unsigned PARAM_W  = 16;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;
   localparam logic [BYTE_W-1:0] MIN_PACKET  = 8'd6;

   typedef enum logic [1:0] {
      VERDICT_OK      = 2'd0,
      VERDICT_CORRUPT = 2'd1,
      VERDICT_WAIT    = 2'd2
   } verdict_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EXPECTED_ID = 1'd0,
      CSR_READ_COUNT  = 1'd1
   } csr_index_type;

   // Per-packet state apart from the byte count, whose width follows a parameter
   typedef struct packed {
      logic              header_good;
      logic [BYTE_W-1:0] packet_id;
      logic [BYTE_W-1:0] length_field;
      logic [BYTE_W-1:0] error_field;
      logic [BYTE_W-1:0] param_low;
      logic [BYTE_W-1:0] param_high;
      logic [BYTE_W-1:0] running_sum;
      logic              sum_matched;
      logic              sum_position_seen;
      logic              store_overflow;
   } pkt_view_type;

endpackage

`default_nettype wire

@@ design/sspc_ifs.sv @@
// Channel interfaces of the servo status packet checker.
// Depends on sspc_pkg for the field widths.
`default_nettype none

interface sspc_req_if;
   logic                        valid;
   logic                        ready;
   logic [sspc_pkg::BYTE_W-1:0] status_byte;
   logic                        last_byte;

   modport source (output valid, output status_byte, output last_byte, input ready);
   modport sink   (input valid, input status_byte, input last_byte, output ready);
endinterface

interface sspc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   verdict;
   logic [sspc_pkg::BYTE_W-1:0]  error_bits;
   logic                         error_flag;
   logic [sspc_pkg::PARAM_W-1:0] param_word;

   modport source (output valid, output verdict, output error_bits, output error_flag,
                   output param_word, input ready);
   modport sink   (input valid, input verdict, input error_bits, input error_flag,
                   input param_word, output ready);
endinterface

`default_nettype wire

@@ design/sspc_state.sv @@
// Packet state tracker: byte count, header check, captured fields, running sum.
// Gives the state as it stands after the current byte. Depends on sspc_pkg.
`default_nettype none

module sspc_state #(
   parameter int unsigned MAX_PACKET_BYTES = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         last_byte,
   input  wire logic [sspc_pkg::BYTE_W-1:0]  status_byte,
   output      logic [$clog2(MAX_PACKET_BYTES+1)-1:0] count_out,
   output      sspc_pkg::pkt_view_type       view_out
);
   import sspc_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET_BYTES);

   localparam pkt_view_type VIEW_RESET = '{
      header_good: 1'b1, packet_id: '0, length_field: '0, error_field: '0,
      param_low: '0, param_high: '0, running_sum: '0, sum_matched: 1'b0,
      sum_position_seen: 1'b0, store_overflow: 1'b0};

   logic [CNT_W-1:0]  count_ff, count_in;
   pkt_view_type      view_ff, view_in;
   logic [CNT_W-1:0]  count_post;
   pkt_view_type      view_post;
   logic [BYTE_W-1:0] len_eff;
   logic [BYTE_W:0]   sum_end;
   logic [BYTE_W:0]   idx_wide;

   always_comb begin
      count_post = count_ff;
      view_post  = view_ff;
      len_eff    = (count_ff == CNT_W'(3)) ? status_byte : view_ff.length_field;
      sum_end    = {1'b0, len_eff} + (BYTE_W+1)'(2);
      idx_wide   = (BYTE_W+1)'(count_ff);
      if (count_ff >= CNT_MAX) begin
         // drop the byte, the packet is spoilt
         view_post.store_overflow = 1'b1;
      end else begin
         count_post = count_ff + CNT_W'(1);
         if (count_ff < CNT_W'(2)) begin
            if (status_byte != HEADER_BYTE) view_post.header_good = 1'b0;
         end else begin
            unique case (count_ff)
               CNT_W'(2): view_post.packet_id    = status_byte;
               CNT_W'(3): view_post.length_field = status_byte;
               CNT_W'(4): view_post.error_field  = status_byte;
               CNT_W'(5): view_post.param_low    = status_byte;
               CNT_W'(6): view_post.param_high   = status_byte;
               default: ;
            endcase
            if (idx_wide <= sum_end) begin
               view_post.running_sum = view_ff.running_sum + status_byte;
            end else if (idx_wide == sum_end + (BYTE_W+1)'(1)) begin
               view_post.sum_position_seen = 1'b1;
               view_post.sum_matched       = (~view_ff.running_sum) == status_byte;
            end
         end
      end
   end

   // Clear everything once the final byte has gone through
   always_comb begin
      count_in = count_ff;
      view_in  = view_ff;
      if (advance) begin
         count_in = last_byte ? '0 : count_post;
         view_in  = last_byte ? VIEW_RESET : view_post;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         view_ff  <= VIEW_RESET;
      end else begin
         count_ff <= count_in;
         view_ff  <= view_in;
      end
   end

   assign count_out = count_post;
   assign view_out  = view_post;

endmodule

`default_nettype wire

@@ design/sspc_result.sv @@
// Verdict logic and result register of the servo status packet checker.
// Depends on sspc_pkg and the response channel interface.
`default_nettype none

module sspc_result #(
   parameter int unsigned CNT_W = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire logic [CNT_W-1:0]              count,
   input  wire sspc_pkg::pkt_view_type        view,
   input  wire logic [sspc_pkg::BYTE_W-1:0]   expected_id,
   input  wire logic [sspc_pkg::RDCNT_W-1:0]  read_count,
   output      logic                          free,
   sspc_rsp_if.source                         rsp
);
   import sspc_pkg::*;

   logic              valid_ff, valid_in;
   verdict_type       verdict_ff, verdict_in;
   logic [BYTE_W-1:0] error_ff, error_in;
   logic              flag_ff, flag_in;
   logic [PARAM_W-1:0] param_ff, param_in;
   logic [BYTE_W-1:0] size;
   logic [BYTE_W-1:0] want;

   assign size = BYTE_W'(count);
   assign want = MIN_PACKET + BYTE_W'(read_count);
   assign free = !valid_ff || rsp.ready;

   always_comb begin
      priority if (view.store_overflow || size < MIN_PACKET || !view.header_good ||
                   !view.sum_position_seen || !view.sum_matched) begin
         verdict_in = VERDICT_CORRUPT;
      end else if (view.packet_id != expected_id || size != want) begin
         verdict_in = VERDICT_WAIT;
      end else begin
         verdict_in = VERDICT_OK;
      end
      if (verdict_in == VERDICT_OK) begin
         error_in = view.error_field;
         flag_in  = view.error_field != '0;
         param_in = {view.param_high, view.param_low};
      end else begin
         error_in = '0;
         flag_in  = 1'b0;
         param_in = '0;
      end
      valid_in = load ? 1'b1 : (valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads only with a new verdict
   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff <= verdict_in;
         error_ff   <= error_in;
         flag_ff    <= flag_in;
         param_ff   <= param_in;
      end
   end

   assign rsp.valid      = valid_ff;
   assign rsp.verdict    = verdict_ff;
   assign rsp.error_bits = error_ff;
   assign rsp.error_flag = flag_ff;
   assign rsp.param_word = param_ff;

endmodule

`default_nettype wire

@@ design/servo_status_packet_check_core.sv @@
// Servo status packet checker, top level. A final byte is held in the input
// register, then its verdict in the result register. Throughput: one byte
// per cycle, set by the single update of the count and running sum, unless
// a final byte waits for the result register. Reset (synchronous) clears the
// packet state and the pipeline; expected_id returns to 1, read_count to 2.
`default_nettype none

module servo_status_packet_check_core #(
   parameter int unsigned MAX_PACKET_BYTES = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [sspc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [sspc_pkg::BYTE_W-1:0]       csr_wdata,
   sspc_req_if.sink                               req_bus,
   sspc_rsp_if.source                             rsp_bus
);
   import sspc_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);

   logic [BYTE_W-1:0]  expected_id_ff, expected_id_in;
   logic [RDCNT_W-1:0] read_count_ff, read_count_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0]  s1_byte_ff;
   logic               s1_last_ff;
   logic               s1_go;
   logic               rsp_free;
   logic               req_take;
   logic [CNT_W-1:0]   count_post;
   pkt_view_type       view_post;

   always_comb begin
      expected_id_in = expected_id_ff;
      read_count_in  = read_count_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_EXPECTED_ID: expected_id_in = csr_wdata;
            CSR_READ_COUNT:  read_count_in  = csr_wdata[RDCNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= 8'd1;
         read_count_ff  <= 6'd2;
      end else begin
         expected_id_ff <= expected_id_in;
         read_count_ff  <= read_count_in;
      end
   end

   // Hold a final byte until the result register has room
   assign s1_go         = s1_valid_ff && (!s1_last_ff || rsp_free);
   assign req_bus.ready = !s1_valid_ff || s1_go;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign s1_valid_in   = req_take ? 1'b1 : (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_bus.status_byte;
         s1_last_ff <= req_bus.last_byte;
      end
   end

   sspc_state #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_state (
      .clock       (clock),
      .reset       (reset),
      .advance     (s1_go),
      .last_byte   (s1_last_ff),
      .status_byte (s1_byte_ff),
      .count_out   (count_post),
      .view_out    (view_post)
   );

   sspc_result #(
      .CNT_W (CNT_W)
   ) u_result (
      .clock       (clock),
      .reset       (reset),
      .load        (s1_go && s1_last_ff),
      .count       (count_post),
      .view        (view_post),
      .expected_id (expected_id_ff),
      .read_count  (read_count_ff),
      .free        (rsp_free),
      .rsp         (rsp_bus)
   );

endmodule

`default_nettype wire
